// ----- sv/aabb_cr_pkg.sv -----
// Package for the AABB collision resolver: register indexes, item codes,
// fixed register widths and reset values.
// No dependencies; used by aabb_collision_resolver.
`default_nettype none

package aabb_cr_pkg;

  // Fixed widths of the configuration registers and of the rebound scaling.
  localparam int HALF_W        = 18;
  localparam int REBOUND_W     = 9;
  localparam int REBOUND_SHIFT = 8;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = HALF_W;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_SIZE      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REBOUND_FACTOR = 1'b1;

  // Register reset values: half-size 10.0 and rebound factor 1.0.
  localparam logic [HALF_W-1:0]    HALF_SIZE_RST      = 18'd2560;
  localparam logic [REBOUND_W-1:0] REBOUND_FACTOR_RST = 9'd256;

  // Item function codes.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  // Box kinds.
  localparam logic KIND_SOLID   = 1'b0;
  localparam logic KIND_CONTAIN = 1'b1;

endpackage

`default_nettype wire

// ----- sv/aabb_collision_resolver.sv -----
// One square body resolved against axis-aligned boxes, one word per cycle unless stalled.
// Depends on aabb_cr_pkg for register indexes, item codes and fixed widths.
// Each input word is either a load of position and velocity or a resolve
// against a solid or containment box.
`default_nettype none

// The block accepts one word per clock cycle while the result side does not
// stall, and returns one result word for each. The word is first captured in
// an input register; its result then moves into the result register unless
// that register is still held by a stalled receiver. A single combinational
// pass feeds both that register and the body state, so the following word already
// sees the updated body. That pass covers the saturating box edges, the
// overlap and centre comparisons, the push, and the multiplication of the
// velocity by the rebound factor. s_axis_tready follows m_axis_tready
// combinationally when both registers are full; an empty input register
// always accepts. Configuration writes are taken in any cycle (cfg_ready is
// tied high) and should only be issued while the block is idle.
module aabb_collision_resolver #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  // Configuration write channel.
  input  wire logic                                         cfg_valid,
  output logic                                              cfg_ready,
  input  wire logic [aabb_cr_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  wire logic [aabb_cr_pkg::CFG_DATA_W-1:0]           cfg_data,
  // Input words.
  input  wire logic                                         s_axis_tvalid,
  output logic                                              s_axis_tready,
  // From bit 0: load_pos_x, load_pos_y, load_vel_x, load_vel_y,
  // box_min_x, box_max_x, box_min_y, box_max_y.
  input  wire logic [8*COORD_BITS-1:0]                      s_axis_tdata,
  // From bit 0: func, box_kind.
  input  wire logic [1:0]                                   s_axis_tuser,
  // Result words.
  output logic                                              m_axis_tvalid,
  input  wire logic                                         m_axis_tready,
  // From bit 0: out_pos_x, out_pos_y, out_vel_x, out_vel_y, zero fill.
  output logic [((4*COORD_BITS+7)/8)*8-1:0]                 m_axis_tdata,
  // Bit 0: hit.
  output logic                                              m_axis_tuser
);

  localparam int CW    = COORD_BITS;
  // Working width: holds sums of coordinates and half-size and the rebound
  // product before saturation.
  localparam int AW    = CW + aabb_cr_pkg::REBOUND_W + 2;
  localparam int OUT_W = ((4*CW+7)/8)*8;

  localparam logic signed [AW-1:0] SMAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // Sign extension of a coordinate to the working width.
  function automatic logic signed [AW-1:0] ext(input logic signed [CW-1:0] a);
    return {{(AW-CW){a[CW-1]}}, a};
  endfunction

  // Saturation of a working-width value to the coordinate range.
  function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SMAX) begin
      r = SMAX[CW-1:0];
    end else if (v < SMIN) begin
      r = SMIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Rebound: negate, scale by the unsigned Q1.8 factor, floor-shift and saturate.
  function automatic logic signed [CW-1:0] rebound(
    input logic signed [CW-1:0]                 v,
    input logic [aabb_cr_pkg::REBOUND_W-1:0]    rf
  );
    logic signed [CW:0]                         nv;
    logic signed [aabb_cr_pkg::REBOUND_W:0]     rf_s;
    logic signed [AW-1:0]                       prod;
    nv   = -{v[CW-1], v};
    rf_s = {1'b0, rf};
    prod = AW'(nv) * AW'(rf_s);
    return sat(prod >>> aabb_cr_pkg::REBOUND_SHIFT);
  endfunction

  // Configuration registers.
  logic [aabb_cr_pkg::HALF_W-1:0]    half_size;
  logic [aabb_cr_pkg::REBOUND_W-1:0] rebound_factor;

  // Body state.
  logic signed [CW-1:0] pos_x, pos_y, vel_x, vel_y;

  // Input register.
  logic              in_vld;
  logic              in_func;
  logic              in_kind;
  logic [8*CW-1:0]   in_data;

  // Result register.
  logic [4*CW-1:0]   out_data;
  logic              out_hit;

  logic advance;

  // Fields of the captured word.
  logic signed [CW-1:0] ld_px, ld_py, ld_vx, ld_vy;
  logic signed [CW-1:0] bmin_x, bmax_x, bmin_y, bmax_y;

  // Datapath signals.
  logic signed [AW-1:0] h;
  logic signed [CW-1:0] clo_x, chi_x, clo_y, chi_y;
  logic signed [CW-1:0] smin_x, smax_x, smin_y, smax_y;
  logic signed [AW-1:0] ov_x, ov_y;
  logic signed [AW-1:0] ssum_x, ssum_y, bsum_x, bsum_y;
  logic                 up_x, up_y;
  logic signed [CW-1:0] push_x, push_y;
  logic signed [CW-1:0] rb_x, rb_y;
  logic signed [CW-1:0] pos_x_next, pos_y_next, vel_x_next, vel_y_next;
  logic                 hit_next;

  assign ld_px  = in_data[0*CW +: CW];
  assign ld_py  = in_data[1*CW +: CW];
  assign ld_vx  = in_data[2*CW +: CW];
  assign ld_vy  = in_data[3*CW +: CW];
  assign bmin_x = in_data[4*CW +: CW];
  assign bmax_x = in_data[5*CW +: CW];
  assign bmin_y = in_data[6*CW +: CW];
  assign bmax_y = in_data[7*CW +: CW];

  // Handshake: the result register moves when empty or taken, and the input
  // register refills whenever it is empty or moving on.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_vld || advance;
  assign cfg_ready     = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_size      <= aabb_cr_pkg::HALF_SIZE_RST;
      rebound_factor <= aabb_cr_pkg::REBOUND_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aabb_cr_pkg::REG_HALF_SIZE:      half_size <= cfg_data;
        aabb_cr_pkg::REG_REBOUND_FACTOR:
          rebound_factor <= cfg_data[aabb_cr_pkg::REBOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // Containment box shrunk by the half-size.
  assign h     = {{(AW-aabb_cr_pkg::HALF_W){1'b0}}, half_size};
  assign clo_x = sat(ext(bmin_x) + h);
  assign chi_x = sat(ext(bmax_x) - h);
  assign clo_y = sat(ext(bmin_y) + h);
  assign chi_y = sat(ext(bmax_y) - h);

  // Body extent and overlap with a solid box.
  assign smin_x = sat(ext(pos_x) - h);
  assign smax_x = sat(ext(pos_x) + h);
  assign smin_y = sat(ext(pos_y) - h);
  assign smax_y = sat(ext(pos_y) + h);

  assign ov_x = ((smax_x < bmax_x) ? ext(smax_x) : ext(bmax_x))
              - ((smin_x > bmin_x) ? ext(smin_x) : ext(bmin_x));
  assign ov_y = ((smax_y < bmax_y) ? ext(smax_y) : ext(bmax_y))
              - ((smin_y > bmin_y) ? ext(smin_y) : ext(bmin_y));

  // Push direction from the centres, compared as edge sums; equal centres
  // push against the velocity.
  assign ssum_x = ext(smin_x) + ext(smax_x);
  assign ssum_y = ext(smin_y) + ext(smax_y);
  assign bsum_x = ext(bmin_x) + ext(bmax_x);
  assign bsum_y = ext(bmin_y) + ext(bmax_y);
  assign up_x   = (ssum_x > bsum_x) || ((ssum_x == bsum_x) && (vel_x <= 0));
  assign up_y   = (ssum_y > bsum_y) || ((ssum_y == bsum_y) && (vel_y <= 0));
  assign push_x = sat(up_x ? ext(pos_x) + ov_x : ext(pos_x) - ov_x);
  assign push_y = sat(up_y ? ext(pos_y) + ov_y : ext(pos_y) - ov_y);

  // Rebounded velocities, used on whichever axis is hit.
  assign rb_x = rebound(vel_x, rebound_factor);
  assign rb_y = rebound(vel_y, rebound_factor);

  // Next body state and hit flag for the word in the input register.
  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    vel_x_next = vel_x;
    vel_y_next = vel_y;
    hit_next   = 1'b0;
    if (in_func == aabb_cr_pkg::FUNC_LOAD) begin
      pos_x_next = ld_px;
      pos_y_next = ld_py;
      vel_x_next = ld_vx;
      vel_y_next = ld_vy;
    end else if (in_kind == aabb_cr_pkg::KIND_CONTAIN) begin
      // The low edge is tested first; in an inverted box a position below
      // the low bound goes there and any other position goes to the high one.
      if (pos_x < clo_x) begin
        pos_x_next = clo_x;
        vel_x_next = rb_x;
        hit_next   = 1'b1;
      end else if (pos_x > chi_x) begin
        pos_x_next = chi_x;
        vel_x_next = rb_x;
        hit_next   = 1'b1;
      end
      if (pos_y < clo_y) begin
        pos_y_next = clo_y;
        vel_y_next = rb_y;
        hit_next   = 1'b1;
      end else if (pos_y > chi_y) begin
        pos_y_next = chi_y;
        vel_y_next = rb_y;
        hit_next   = 1'b1;
      end
    end else if ((ov_x > 0) && (ov_y > 0)) begin
      // Push out along the axis of smaller overlap; a tie goes to Y.
      hit_next = 1'b1;
      if (ov_x < ov_y) begin
        pos_x_next = push_x;
        vel_x_next = rb_x;
      end else begin
        pos_y_next = push_y;
        vel_y_next = rb_y;
      end
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser[0];
      in_kind <= s_axis_tuser[1];
      in_data <= s_axis_tdata;
    end
  end

  // Body state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      vel_x         <= '0;
      vel_y         <= '0;
    end else if (advance) begin
      m_axis_tvalid <= in_vld;
      if (in_vld) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
        vel_x <= vel_x_next;
        vel_y <= vel_y_next;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance && in_vld) begin
      out_data <= {vel_y_next, vel_x_next, pos_y_next, pos_x_next};
      out_hit  <= hit_next;
    end
  end

  assign m_axis_tdata = OUT_W'(out_data);
  assign m_axis_tuser = out_hit;

  // A result word only appears after a word has been held in the input register.
  a_out_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_vld))
    else $error("result word appeared with no captured input word");

  // A load never reports a hit.
  a_load_no_hit: assert property (@(posedge clk) disable iff (rst)
    (in_vld && advance && (in_func == aabb_cr_pkg::FUNC_LOAD)) |=> !m_axis_tuser)
    else $error("load word reported a hit");

  // The body state moves only when a word is committed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_vld && advance) |=> ($stable(pos_x) && $stable(pos_y)
                              && $stable(vel_x) && $stable(vel_y)))
    else $error("body state changed with no committed word");

  // A pending result always shows the current body state.
  a_result_is_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_data == {vel_y, vel_x, pos_y, pos_x}))
    else $error("result word differs from body state");

endmodule

`default_nettype wire
